// ===== rtl/hcsc_pkg.sv =====
// Shared constants and types for the height-grid cell slope and cliff block.
`default_nettype none

package hcsc_pkg;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int GRID_REG_W  = 9;
    localparam int THRESH_W    = 16;
    localparam int COUNT_W     = 17;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIFF_THRESHOLD = 1'b1;

    localparam logic [GRID_REG_W-1:0] GRID_SIZE_RESET = 9'd256;
    localparam logic [THRESH_W-1:0]   THRESH_RESET    = 16'd1;

    // per-cell control bits worked out by the front end
    typedef struct packed {
        logic has_west;
        logic has_north;
        logic clear_count;
        logic last;
    } t_cell_flags;

    localparam int FLAGS_W = $bits(t_cell_flags);

endpackage

`default_nettype wire

// ===== rtl/hcsc_if.sv =====
// Request channel interfaces: corner levels in, cell results out.
`default_nettype none

interface hcsc_level_if #(
    parameter int LEVEL_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [LEVEL_WIDTH-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface hcsc_cell_if #(
    parameter int LEVEL_WIDTH = 16
);
    logic                               valid;
    logic                               ready;
    logic signed [LEVEL_WIDTH-1:0]      average;
    logic        [LEVEL_WIDTH-1:0]      slope;
    logic        [hcsc_pkg::COUNT_W-1:0] cliff_count;
    logic                               last_cell;

    modport source (output valid, output average, output slope, output cliff_count,
                    output last_cell, input ready);
    modport sink   (input valid, input average, input slope, input cliff_count,
                    input last_cell, output ready);
endinterface

`default_nettype wire

// ===== rtl/hcsc_front.sv =====
// Front end: takes corners, keeps the corner line buffer and forms cell requests.
`default_nettype none

module hcsc_front #(
    parameter int MAX_GRID    = 256,
    parameter int LEVEL_WIDTH = 16,
    parameter int COL_W       = 9,
    parameter int XW          = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_restart,
    input  wire logic [COL_W-1:0]              i_grid,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [LEVEL_WIDTH-1:0] i_level,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output logic signed [LEVEL_WIDTH-1:0]      o_tl,
    output logic signed [LEVEL_WIDTH-1:0]      o_tr,
    output logic signed [LEVEL_WIDTH-1:0]      o_bl,
    output logic signed [LEVEL_WIDTH-1:0]      o_br,
    output logic [XW-1:0]                      o_x,
    output hcsc_pkg::t_cell_flags              o_flags
);

    localparam int DEPTH = MAX_GRID + 1;

    logic signed [LEVEL_WIDTH-1:0] r_mem [DEPTH];
    logic signed [LEVEL_WIDTH-1:0] r_above;
    logic signed [LEVEL_WIDTH-1:0] r_ul;
    logic signed [LEVEL_WIDTH-1:0] r_ll;
    logic [COL_W-1:0]              r_col, n_col;
    logic [COL_W-1:0]              r_row, n_row;
    logic                          accept;
    logic                          end_col;
    logic                          end_row;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign end_col = (r_col == i_grid);
    assign end_row = (r_row == i_grid);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (end_col) begin
                n_col = '0;
                n_row = end_row ? '0 : r_row + COL_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line buffer: the next column is always prefetched, so the corner above is ready
    // when it arrives; write and read addresses differ unless a restart hits column 0.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_col] <= i_level;
        end
        r_above <= r_mem[n_col];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ul <= r_above;
            r_ll <= i_level;
        end
    end

    assign o_push = accept && (r_row != '0) && (r_col != '0);
    assign o_tl   = r_ul;
    assign o_tr   = r_above;
    assign o_bl   = r_ll;
    assign o_br   = i_level;
    assign o_x    = XW'(r_col - COL_W'(1));

    always_comb begin
        o_flags.has_west    = (r_col > COL_W'(1));
        o_flags.has_north   = (r_row > COL_W'(1));
        o_flags.clear_count = (r_row == COL_W'(1)) && (r_col == COL_W'(1));
        o_flags.last        = end_row && end_col;
    end

    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= i_grid) && (r_row <= i_grid))
        else $error("corner position beyond grid");

endmodule

`default_nettype wire

// ===== rtl/hcsc_queue.sv =====
// Small FIFO between front end and back end.
`default_nettype none

module hcsc_queue #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[PW-1:0] == PW'(r_wptr - r_rptr))
        else $error("queue fill count out of step with pointers");

endmodule

`default_nettype wire

// ===== rtl/hcsc_back.sv =====
// Back end: cell average and slope, north/west cliff test, running count, output register.
`default_nettype none

module hcsc_back #(
    parameter int MAX_GRID    = 256,
    parameter int LEVEL_WIDTH = 16,
    parameter int XW          = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [hcsc_pkg::THRESH_W-1:0]       i_threshold,
    input  wire logic                                i_empty,
    output logic                                     o_pop,
    input  wire logic signed [LEVEL_WIDTH-1:0]       i_tl,
    input  wire logic signed [LEVEL_WIDTH-1:0]       i_tr,
    input  wire logic signed [LEVEL_WIDTH-1:0]       i_bl,
    input  wire logic signed [LEVEL_WIDTH-1:0]       i_br,
    input  wire logic [XW-1:0]                       i_x,
    input  wire hcsc_pkg::t_cell_flags               i_flags,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [LEVEL_WIDTH-1:0]            o_average,
    output logic [LEVEL_WIDTH-1:0]                   o_slope,
    output logic [hcsc_pkg::COUNT_W-1:0]             o_count,
    output logic                                     o_last
);

    localparam int LW  = LEVEL_WIDTH;
    localparam int SW  = LW + 2;
    localparam int CMW = (LW > hcsc_pkg::THRESH_W) ? LW : hcsc_pkg::THRESH_W;
    localparam int NW  = hcsc_pkg::COUNT_W;

    function automatic logic [LW-1:0] abs_diff(input logic signed [LW-1:0] a,
                                               input logic signed [LW-1:0] b);
        logic signed [LW:0] d;
        d = {a[LW-1], a} - {b[LW-1], b};
        abs_diff = d[LW] ? LW'(-d) : LW'(d);
    endfunction

    // stage one
    logic                          r_s1_valid;
    logic signed [LW-1:0]          r_s1_avg;
    logic [LW-1:0]                 r_s1_slope;
    logic [XW-1:0]                 r_s1_x;
    hcsc_pkg::t_cell_flags         r_s1_flags;
    logic signed [LW-1:0]          r_rd;
    logic                          r_fwd;
    logic signed [LW-1:0]          r_fwd_avg;
    logic signed [LW-1:0]          r_avg_mem [MAX_GRID];

    // output register
    logic                          r_out_valid;
    logic signed [LW-1:0]          r_out_avg;
    logic [LW-1:0]                 r_out_slope;
    logic [NW-1:0]                 r_out_count;
    logic                          r_out_last;

    logic                          adv;
    logic                          s1_load;
    logic signed [SW-1:0]          sum;
    logic [SW-1:0]                 abs_sum;
    logic [SW-1:0]                 mag;
    logic signed [LW-1:0]          avg;
    logic [LW-1:0]                 d0, d1, d2, d3, m01, m23, slope;
    logic signed [LW-1:0]          north;
    logic [LW-1:0]                 dw, dn;
    logic                          inc_w, inc_n;
    logic [NW-1:0]                 base, n_count;

    assign adv     = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_load = !i_empty && (!r_s1_valid || adv);
    assign o_pop   = s1_load;

    // average rounded half away from zero, slope as largest of four corner differences
    always_comb begin
        sum     = SW'(i_tl) + SW'(i_tr) + SW'(i_bl) + SW'(i_br);
        abs_sum = sum[SW-1] ? SW'(-sum) : SW'(sum);
        mag     = (abs_sum + SW'(2)) >> 2;
        avg     = sum[SW-1] ? LW'(-mag) : LW'(mag);
        d0      = abs_diff(i_tl, i_br);
        d1      = abs_diff(i_tr, i_bl);
        d2      = abs_diff(i_tl, i_tr);
        d3      = abs_diff(i_tl, i_bl);
        m01     = (d1 > d0) ? d1 : d0;
        m23     = (d3 > d2) ? d3 : d2;
        slope   = (m23 > m01) ? m23 : m01;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_avg   <= avg;
            r_s1_slope <= slope;
            r_s1_x     <= i_x;
            r_s1_flags <= i_flags;
            // cell leaving stage one writes the same column this cycle
            r_fwd      <= adv && (r_s1_x == i_x);
            r_fwd_avg  <= r_s1_avg;
        end
    end

    // previous row of cell averages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_avg_mem[r_s1_x] <= r_s1_avg;
        end
        if (s1_load) begin
            r_rd <= r_avg_mem[i_x];
        end
    end

    assign north = r_fwd ? r_fwd_avg : r_rd;

    always_comb begin
        dw      = abs_diff(r_s1_avg, r_out_avg);
        dn      = abs_diff(r_s1_avg, north);
        inc_w   = r_s1_flags.has_west && (CMW'(dw) >= CMW'(i_threshold));
        inc_n   = r_s1_flags.has_north && (CMW'(dn) >= CMW'(i_threshold));
        base    = r_s1_flags.clear_count ? '0 : r_out_count;
        n_count = base + NW'(inc_w) + NW'(inc_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_count <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_out_count <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_avg   <= r_s1_avg;
            r_out_slope <= r_s1_slope;
            r_out_last  <= r_s1_flags.last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_out_avg;
    assign o_slope   = r_out_slope;
    assign o_count   = r_out_count;
    assign o_last    = r_out_last;

    a_first_cell_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_s1_flags.clear_count |=> r_out_count <= NW'(2))
        else $error("cliff count not cleared on first cell of grid");

endmodule

`default_nettype wire

// ===== rtl/heightmap_cell_slope_cliff.sv =====
// Top level: configuration registers, front end, request queue and back end.
//
//  channel   dir  handshake     payload
//  i_level   in   valid/ready   level (signed corner level, raster order)
//  o_cell    out  valid/ready   average, slope, cliff_count, last_cell
//  i_cfg     in   i_cfg_we      i_cfg_index, i_cfg_data (write only)
//
// One corner is taken per cycle while the queue is not full; a closing corner's cell
// result passes through the queue, the stage-one register and the output register.
// The corner line buffer is read one column ahead, which sets the one-per-cycle rate.
// Reset is synchronous; line buffers are not cleared, row zero fills them first.
// A four-entry queue parts the front end from the back end; the front end stalls
// only when it is full.
`default_nettype none

module heightmap_cell_slope_cliff #(
    parameter int MAX_GRID    = 256,
    parameter int LEVEL_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hcsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [hcsc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    hcsc_level_if.sink                                i_level,
    hcsc_cell_if.source                               o_cell
);

    localparam int COL_W   = $clog2(MAX_GRID + 1);
    localparam int XW      = $clog2(MAX_GRID);
    localparam int GW      = (COL_W > hcsc_pkg::GRID_REG_W) ? COL_W : hcsc_pkg::GRID_REG_W;
    localparam int Q_DEPTH = 4;
    localparam int QW      = hcsc_pkg::FLAGS_W + XW + 4 * LEVEL_WIDTH;

    logic [hcsc_pkg::GRID_REG_W-1:0] r_grid_size;
    logic [hcsc_pkg::THRESH_W-1:0]   r_threshold;
    logic                            restart;
    logic [GW-1:0]                   gs_ext;
    logic [GW-1:0]                   eff;
    logic [COL_W-1:0]                grid;

    logic                            f_push;
    logic signed [LEVEL_WIDTH-1:0]   f_tl, f_tr, f_bl, f_br;
    logic [XW-1:0]                   f_x;
    hcsc_pkg::t_cell_flags           f_flags;

    logic [QW-1:0]                   q_wdata, q_rdata;
    logic                            q_full, q_empty, q_pop;

    logic signed [LEVEL_WIDTH-1:0]   b_tl, b_tr, b_bl, b_br;
    logic [XW-1:0]                   b_x;
    hcsc_pkg::t_cell_flags           b_flags;

    assign restart = i_cfg_we && (i_cfg_index == hcsc_pkg::CFG_GRID_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= hcsc_pkg::GRID_SIZE_RESET;
            r_threshold <= hcsc_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hcsc_pkg::CFG_GRID_SIZE: begin
                    r_grid_size <= i_cfg_data[hcsc_pkg::GRID_REG_W-1:0];
                end
                hcsc_pkg::CFG_CLIFF_THRESHOLD: begin
                    r_threshold <= i_cfg_data[hcsc_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, anything above the buffer size is clamped
    always_comb begin
        gs_ext = GW'(r_grid_size);
        if (gs_ext == '0) begin
            eff = GW'(1);
        end else if (gs_ext > GW'(MAX_GRID)) begin
            eff = GW'(MAX_GRID);
        end else begin
            eff = gs_ext;
        end
        grid = COL_W'(eff);
    end

    hcsc_front #(
        .MAX_GRID    (MAX_GRID),
        .LEVEL_WIDTH (LEVEL_WIDTH),
        .COL_W       (COL_W),
        .XW          (XW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_grid    (grid),
        .i_valid   (i_level.valid),
        .o_ready   (i_level.ready),
        .i_level   (i_level.level),
        .i_q_full  (q_full),
        .o_push    (f_push),
        .o_tl      (f_tl),
        .o_tr      (f_tr),
        .o_bl      (f_bl),
        .o_br      (f_br),
        .o_x       (f_x),
        .o_flags   (f_flags)
    );

    assign q_wdata = {f_flags, f_x, f_tl, f_tr, f_bl, f_br};

    hcsc_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_flags, b_x, b_tl, b_tr, b_bl, b_br} = q_rdata;

    hcsc_back #(
        .MAX_GRID    (MAX_GRID),
        .LEVEL_WIDTH (LEVEL_WIDTH),
        .XW          (XW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .i_tl        (b_tl),
        .i_tr        (b_tr),
        .i_bl        (b_bl),
        .i_br        (b_br),
        .i_x         (b_x),
        .i_flags     (b_flags),
        .o_valid     (o_cell.valid),
        .i_ready     (o_cell.ready),
        .o_average   (o_cell.average),
        .o_slope     (o_cell.slope),
        .o_count     (o_cell.cliff_count),
        .o_last      (o_cell.last_cell)
    );

endmodule

`default_nettype wire
